[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ESC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ESC_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/esc_pkg.sv]
// Types, constants and arithmetic helpers of the sensor compensation block.
`timescale 1ns / 1ps

package esc_pkg;

    // Configuration port geometry and register indexes.
    localparam int ESC_AW = 6;
    localparam logic [2:0] REG_TEMP_CAL = 3'd0;
    localparam logic [2:0] REG_PRESS_A  = 3'd1;
    localparam logic [2:0] REG_PRESS_B  = 3'd2;
    localparam logic [2:0] REG_PRESS_C  = 3'd3;
    localparam logic [2:0] REG_HUM_A    = 3'd4;
    localparam logic [2:0] REG_HUM_B    = 3'd5;

    // Queue between the front and the back end.
    localparam int ESC_QDEPTH = 8;
    localparam int ESC_QAW    = 3;

    // One quotient bit per divider stage.
    localparam int ESC_DIV_STEPS = 64;

    // Compensation constants.
    localparam logic [31:0] ESC_HUM_FINE_OFS = 32'd76800;
    localparam logic signed [32:0] ESC_PRESS_FINE_OFS = 33'sd128000;
    localparam logic [31:0] ESC_HUM_LIMIT = 32'd419430400;
    localparam logic [20:0] ESC_PRESS_BASE = 21'd1048576;
    localparam logic [63:0] ESC_PRESS_SCALE = 64'd3125;
    localparam logic [31:0] ESC_HUM_S_OFS = 32'd2097152;
    localparam logic [31:0] ESC_HUM_ROUND15 = 32'd16384;
    localparam logic [31:0] ESC_HUM_ROUND14 = 32'd8192;
    localparam logic [16:0] ESC_HUM_MAX = 17'd102400;

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
        logic [15:0] adc_humidity;
    } t_esc_in;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [16:0]        humidity;
        logic [31:0]        pressure;
        logic               pressure_invalid;
    } t_esc_out;

    // Calibration registers as written through the configuration port.
    typedef struct packed {
        logic [47:0] temp_cal;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [39:0] hum_a;
        logic [23:0] hum_b;
    } t_esc_cfg;

    // Queue entry: fine temperature plus the raw readings still to be used.
    typedef struct packed {
        logic [31:0] fine;
        logic [19:0] adc_pressure;
        logic [15:0] adc_humidity;
    } t_esc_fine;

    // Finished fields that ride alongside the pressure division.
    typedef struct packed {
        logic [31:0] temperature;
        logic [16:0] humidity;
        logic        bad;
    } t_esc_tag;

    function automatic logic [31:0] sar32(input logic [31:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sar64(input logic [63:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    // Low 32 bits of a product; equal for signed and unsigned operands.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    function automatic logic [63:0] mul64s16(input logic [63:0] a, input logic [15:0] b);
        logic [63:0] bx;
        bx = {{48{b[15]}}, b};
        return a * bx;
    endfunction

    function automatic logic [63:0] mul64u16(input logic [63:0] a, input logic [15:0] b);
        logic [63:0] bx;
        bx = {48'b0, b};
        return a * bx;
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12_32(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

[rtl/env_sensor_compensation_unit.sv]
// Top level of the sensor compensation block: register file, front, queue, back.
`timescale 1ns / 1ps
// Usage:
// - Calibration words are written through the APB-style port, 64-bit data,
//   register i at byte address 8*i; pready is always high and reads return
//   the stored word. Write them only while no reading is in flight.
// - A reading is a beat on i_item, taken at the rising edge where start is
//   high and busy is low.
// - Each result is a beat on o_result marked by o_result_valid for exactly
//   one cycle; the receiver must take it, there is no back pressure.
// - A new reading can be taken every cycle while busy is low.
// - Each reading passes the front end, the queue, the multiplier stages and
//   the 64-stage pressure divider, one quotient bit per stage.
// - busy rises only when the queue and front end together could overflow;
//   since the back end drains the queue every cycle it stays low in use.
// - Reset clears the calibration words to zero, empties the queue and
//   drops every beat in flight.

module env_sensor_compensation_unit import esc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_esc_in           i_item,
    output logic              o_result_valid,
    output t_esc_out          o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ESC_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    t_esc_cfg         r_cfg;
    logic [2:0]       reg_idx;
    logic             accept, push, empty;
    t_esc_fine        entry, head;
    logic [1:0]       inflight;
    logic [ESC_QAW:0] count;
    logic [ESC_QAW+1:0] occupancy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ESC_AW-1:3];

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_TEMP_CAL: r_cfg.temp_cal <= pwdata[47:0];
                REG_PRESS_A:  r_cfg.press_a  <= pwdata[47:0];
                REG_PRESS_B:  r_cfg.press_b  <= pwdata[47:0];
                REG_PRESS_C:  r_cfg.press_c  <= pwdata[47:0];
                REG_HUM_A:    r_cfg.hum_a    <= pwdata[39:0];
                REG_HUM_B:    r_cfg.hum_b    <= pwdata[23:0];
                default:      ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_idx)
            REG_TEMP_CAL: prdata = {16'b0, r_cfg.temp_cal};
            REG_PRESS_A:  prdata = {16'b0, r_cfg.press_a};
            REG_PRESS_B:  prdata = {16'b0, r_cfg.press_b};
            REG_PRESS_C:  prdata = {16'b0, r_cfg.press_c};
            REG_HUM_A:    prdata = {24'b0, r_cfg.hum_a};
            REG_HUM_B:    prdata = {40'b0, r_cfg.hum_b};
            default:      prdata = '0;
        endcase
    end

    // Hold off new readings only when the queue could not absorb them.
    assign occupancy = {1'b0, count} + {{ESC_QAW{1'b0}}, inflight};
    assign busy      = (occupancy >= (ESC_QAW+2)'(ESC_QDEPTH));
    assign accept    = start && !busy;

    esc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_entry    (entry),
        .o_inflight (inflight)
    );

    esc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (!empty),
        .o_head  (head),
        .o_empty (empty),
        .o_count (count)
    );

    esc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!empty),
        .i_entry  (head),
        .i_cfg    (r_cfg),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

endmodule

[rtl/esc_front.sv]
// Front end: takes readings and derives the fine temperature in two stages.
`timescale 1ns / 1ps

module esc_front import esc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_esc_in   i_item,
    input  t_esc_cfg  i_cfg,
    output logic      o_push,
    output t_esc_fine o_entry,
    output logic [1:0] o_inflight
);

    logic [31:0] t1, t2, t3, a, b;
    logic        r_v1, r_v2;
    logic [31:0] r_ma, r_mb, r_v1f, r_mv2;
    logic [19:0] r_p1, r_p2;
    logic [15:0] r_h1, r_h2;

    // Temperature coefficients.
    assign t1 = {16'b0, i_cfg.temp_cal[15:0]};
    assign t2 = sx16_32(i_cfg.temp_cal[31:16]);
    assign t3 = sx16_32(i_cfg.temp_cal[47:32]);

    // Offsets of the raw temperature from the T1 point.
    assign a = {15'b0, i_item.adc_temperature[19:3]} - {t1[30:0], 1'b0};
    assign b = {16'b0, i_item.adc_temperature[19:4]} - t1;

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one forms the products, stage two the quadratic term.
    always_ff @(posedge i_clk) begin
        r_ma  <= mul32(a, t2);
        r_mb  <= mul32(b, b);
        r_p1  <= i_item.adc_pressure;
        r_h1  <= i_item.adc_humidity;
        r_v1f <= sar32(r_ma, 11);
        r_mv2 <= mul32(sar32(r_mb, 12), t3);
        r_p2  <= r_p1;
        r_h2  <= r_h1;
    end

    assign o_push             = r_v2;
    assign o_entry.fine         = r_v1f + sar32(r_mv2, 14);
    assign o_entry.adc_pressure = r_p2;
    assign o_entry.adc_humidity = r_h2;
    assign o_inflight         = {1'b0, r_v1} + {1'b0, r_v2};

endmodule

[rtl/esc_fifo.sv]
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module esc_fifo import esc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_esc_fine        i_entry,
    input  logic             i_pop,
    output t_esc_fine        o_head,
    output logic             o_empty,
    output logic [ESC_QAW:0] o_count
);

    t_esc_fine          r_mem [ESC_QDEPTH];
    logic [ESC_QAW-1:0] r_wptr, r_rptr;
    logic [ESC_QAW:0]   r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

[rtl/esc_div.sv]
// Pipelined signed-magnitude divider, one quotient bit per stage.
`timescale 1ns / 1ps

module esc_div import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_dvd,
    input  logic [63:0] i_den,
    input  logic        i_neg,
    input  t_esc_tag    i_tag,
    output logic        o_valid,
    output logic [63:0] o_quo,
    output logic        o_neg,
    output t_esc_tag    o_tag
);

    logic        r_vld [ESC_DIV_STEPS];
    logic [63:0] r_rem [ESC_DIV_STEPS];
    logic [63:0] r_dvd [ESC_DIV_STEPS];
    logic [63:0] r_den [ESC_DIV_STEPS];
    logic        r_neg [ESC_DIV_STEPS];
    t_esc_tag    r_tag [ESC_DIV_STEPS];

    logic [63:0] c_rem [ESC_DIV_STEPS];
    logic [63:0] c_dvd [ESC_DIV_STEPS];
    logic [63:0] c_den [ESC_DIV_STEPS];
    logic        c_neg [ESC_DIV_STEPS];
    t_esc_tag    c_tag [ESC_DIV_STEPS];
    logic [63:0] n_rem [ESC_DIV_STEPS];
    logic [63:0] n_dvd [ESC_DIV_STEPS];

    // Inputs of each stage: the port for the first, the previous stage otherwise.
    always_comb begin
        c_rem[0] = '0;
        c_dvd[0] = i_dvd;
        c_den[0] = i_den;
        c_neg[0] = i_neg;
        c_tag[0] = i_tag;
        for (int k = 1; k < ESC_DIV_STEPS; k++) begin
            c_rem[k] = r_rem[k-1];
            c_dvd[k] = r_dvd[k-1];
            c_den[k] = r_den[k-1];
            c_neg[k] = r_neg[k-1];
            c_tag[k] = r_tag[k-1];
        end
    end

    // Restoring step: shift in one dividend bit, subtract when it fits.
    always_comb begin
        logic [64:0] sh;
        logic        qb;
        for (int k = 0; k < ESC_DIV_STEPS; k++) begin
            sh = {c_rem[k], c_dvd[k][63]};
            qb = (sh >= {1'b0, c_den[k]});
            n_rem[k] = qb ? 64'(sh - {1'b0, c_den[k]}) : sh[63:0];
            n_dvd[k] = {c_dvd[k][62:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ESC_DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < ESC_DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ESC_DIV_STEPS; k++) begin
            r_rem[k] <= n_rem[k];
            r_dvd[k] <= n_dvd[k];
            r_den[k] <= c_den[k];
            r_neg[k] <= c_neg[k];
            r_tag[k] <= c_tag[k];
        end
    end

    assign o_valid = r_vld[ESC_DIV_STEPS-1];
    assign o_quo   = r_dvd[ESC_DIV_STEPS-1];
    assign o_neg   = r_neg[ESC_DIV_STEPS-1];
    assign o_tag   = r_tag[ESC_DIV_STEPS-1];

endmodule

[rtl/esc_back.sv]
// Back end: humidity and pressure compensation and the result register.
`timescale 1ns / 1ps

module esc_back import esc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_esc_fine i_entry,
    input  t_esc_cfg  i_cfg,
    output logic      o_valid,
    output t_esc_out  o_result
);

    // Coefficients.
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [15:0] p1, p3, p4, p5, p6, p7, p8, p9;
    logic signed [15:0] p2s, p5s;

    assign h1  = {24'b0, i_cfg.hum_a[7:0]};
    assign h2  = sx16_32(i_cfg.hum_a[23:8]);
    assign h3  = {24'b0, i_cfg.hum_a[31:24]};
    assign h6  = sx8_32(i_cfg.hum_a[39:32]);
    assign h4  = sx12_32(i_cfg.hum_b[11:0]);
    assign h5  = sx12_32(i_cfg.hum_b[23:12]);
    assign p1  = i_cfg.press_a[15:0];
    assign p2s = $signed(i_cfg.press_a[31:16]);
    assign p3  = i_cfg.press_a[47:32];
    assign p4  = i_cfg.press_b[15:0];
    assign p5  = i_cfg.press_b[31:16];
    assign p5s = $signed(p5);
    assign p6  = i_cfg.press_b[47:32];
    assign p7  = i_cfg.press_c[15:0];
    assign p8  = i_cfg.press_c[31:16];
    assign p9  = i_cfg.press_c[47:32];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_out_valid;

    // Stage one: offsets of the fine temperature and first products.
    logic [31:0]        fine, x;
    logic signed [32:0] w1;
    logic signed [65:0] sq_full;
    logic signed [48:0] mp5_full, mp2_full;

    assign fine     = i_entry.fine;
    assign x        = fine - ESC_HUM_FINE_OFS;
    assign w1       = $signed({fine[31], fine}) - ESC_PRESS_FINE_OFS;
    assign sq_full  = 66'(w1) * 66'(w1);
    assign mp5_full = 49'(w1) * 49'(p5s);
    assign mp2_full = 49'(w1) * 49'(p2s);

    logic [31:0]        r1_temp, r1_hpre, r1_mq, r1_mr;
    logic [63:0]        r1_sq;
    logic signed [48:0] r1_mp5, r1_mp2;
    logic [19:0]        r1_adcp;

    always_ff @(posedge i_clk) begin
        r1_temp <= sar32(fine + {fine[29:0], 2'b00} + 32'd128, 8);
        r1_hpre <= {2'b0, i_entry.adc_humidity, 14'b0} - {h4[11:0], 20'b0}
                   - mul32(h5, x) + ESC_HUM_ROUND15;
        r1_mq   <= mul32(x, h6);
        r1_mr   <= mul32(x, h3);
        r1_sq   <= sq_full[63:0];
        r1_mp5  <= mp5_full;
        r1_mp2  <= mp2_full;
        r1_adcp <= i_entry.adc_pressure;
    end

    // Stage two: humidity scale product and the squared pressure terms.
    logic [31:0]        r2_temp, r2_lhs, r2_ms;
    logic [63:0]        r2_w2a, r2_w1ba;
    logic signed [48:0] r2_mp5, r2_mp2;
    logic [19:0]        r2_adcp;

    always_ff @(posedge i_clk) begin
        r2_temp <= r1_temp;
        r2_lhs  <= sar32(r1_hpre, 15);
        r2_ms   <= mul32(sar32(r1_mq, 10), sar32(r1_mr, 11) + 32'd32768);
        r2_w2a  <= mul64s16(r1_sq, p6);
        r2_w1ba <= mul64s16(r1_sq, p3);
        r2_mp5  <= r1_mp5;
        r2_mp2  <= r1_mp2;
        r2_adcp <= r1_adcp;
    end

    // Stage three: pressure offset sum and the divisor product.
    logic [63:0] w1b;
    logic [31:0] r3_temp, r3_lhs, r3_mrhs;
    logic [63:0] r3_w2, r3_mw1c;
    logic [19:0] r3_adcp;

    assign w1b = sar64(r2_w1ba, 8) + ({{15{r2_mp2[48]}}, r2_mp2} << 12);

    always_ff @(posedge i_clk) begin
        r3_temp <= r2_temp;
        r3_lhs  <= r2_lhs;
        r3_mrhs <= mul32(sar32(r2_ms, 10) + ESC_HUM_S_OFS, h2);
        r3_w2   <= r2_w2a + ({{15{r2_mp5[48]}}, r2_mp5} << 17)
                   + ({{48{p4[15]}}, p4} << 35);
        r3_mw1c <= mul64u16(w1b + 64'h0000_8000_0000_0000, p1);
        r3_adcp <= r2_adcp;
    end

    // Stage four: raw humidity product, divisor and dividend base.
    logic [20:0] pdiff;
    logic [31:0] r4_temp, r4_hv;
    logic [63:0] r4_den, r4_num0;

    assign pdiff = ESC_PRESS_BASE - {1'b0, r3_adcp};

    always_ff @(posedge i_clk) begin
        r4_temp <= r3_temp;
        r4_hv   <= mul32(r3_lhs, sar32(r3_mrhs + ESC_HUM_ROUND14, 14));
        r4_den  <= sar64(r3_mw1c, 33);
        r4_num0 <= {12'b0, pdiff, 31'b0} - r3_w2;
    end

    // Stage five: humidity square, scaled dividend, zero-divisor flag.
    logic [31:0] hs;
    logic [31:0] r5_temp, r5_hv, r5_mhs;
    logic [63:0] r5_num, r5_den;
    logic        r5_bad;

    assign hs = sar32(r4_hv, 15);

    always_ff @(posedge i_clk) begin
        r5_temp <= r4_temp;
        r5_hv   <= r4_hv;
        r5_mhs  <= mul32(hs, hs);
        r5_num  <= r4_num0 * ESC_PRESS_SCALE;
        r5_den  <= r4_den;
        r5_bad  <= (r4_den == 64'd0);
    end

    // Stage six: humidity correction product and operand magnitudes.
    logic [31:0] r6_temp, r6_hv, r6_mh1;
    logic [63:0] r6_an, r6_ad;
    logic        r6_neg, r6_bad;

    always_ff @(posedge i_clk) begin
        r6_temp <= r5_temp;
        r6_hv   <= r5_hv;
        r6_mh1  <= mul32(sar32(r5_mhs, 7), h1);
        r6_an   <= r5_num[63] ? 64'd0 - r5_num : r5_num;
        r6_ad   <= r5_den[63] ? 64'd0 - r5_den : r5_den;
        r6_neg  <= r5_num[63] ^ r5_den[63];
        r6_bad  <= r5_bad;
    end

    // Humidity finishes here with its clamp and rides along the division.
    logic [31:0] hv2, hum_c;
    t_esc_tag    div_tag_in, div_tag_out;
    logic        div_valid, div_neg;
    logic [63:0] div_quo;

    assign hv2   = r6_hv - sar32(r6_mh1, 4);
    assign hum_c = hv2[31] ? 32'd0 : ((hv2 > ESC_HUM_LIMIT) ? ESC_HUM_LIMIT : hv2);
    assign div_tag_in.temperature = r6_temp;
    assign div_tag_in.humidity    = hum_c[28:12];
    assign div_tag_in.bad         = r6_bad;

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_dvd   (r6_an),
        .i_den   (r6_ad),
        .i_neg   (r6_neg),
        .i_tag   (div_tag_in),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_tag   (div_tag_out)
    );

    // Stage seven: signed quotient and partial products of its square.
    logic [63:0] pp, s13, ll_full, lh_full;
    logic [63:0] r7_p, r7_ll, r7_mp8;
    logic [30:0] r7_lh;
    t_esc_tag    r7_tag;

    assign pp      = div_neg ? 64'd0 - div_quo : div_quo;
    assign s13     = sar64(pp, 13);
    assign ll_full = {32'b0, s13[31:0]} * {32'b0, s13[31:0]};
    assign lh_full = {32'b0, s13[31:0]} * {32'b0, s13[63:32]};

    always_ff @(posedge i_clk) begin
        r7_p   <= pp;
        r7_ll  <= ll_full;
        r7_lh  <= lh_full[30:0];
        r7_mp8 <= mul64s16(pp, p8);
        r7_tag <= div_tag_out;
    end

    // Stage eight: square assembled, both correction terms.
    logic [63:0] ss;
    logic [63:0] r8_p, r8_mp9, r8_e2;
    t_esc_tag    r8_tag;

    assign ss = r7_ll + {r7_lh, 33'b0};

    always_ff @(posedge i_clk) begin
        r8_p   <= r7_p;
        r8_mp9 <= mul64s16(ss, p9);
        r8_e2  <= sar64(r7_mp8, 19);
        r8_tag <= r7_tag;
    end

    // Result register.
    logic [63:0] press;
    t_esc_out    r_out;

    assign press = sar64(r8_p + sar64(r8_mp9, 25) + r8_e2, 8) + {{44{p7[15]}}, p7, 4'b0};

    always_ff @(posedge i_clk) begin
        r_out.temperature      <= r8_tag.temperature;
        r_out.humidity         <= r8_tag.humidity;
        r_out.pressure         <= r8_tag.bad ? 32'd0 : press[31:0];
        r_out.pressure_invalid <= r8_tag.bad;
    end

    // Valid bits of the back-end stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_v7        <= div_valid;
            r_v8        <= r_v7;
            r_out_valid <= r_v8;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/esc_checker.sv]
// Port-level checks of the sensor compensation block and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esc_checker import esc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     busy,
    input logic     o_result_valid,
    input t_esc_out o_result
);

    // A zero divisor always comes with a zero pressure field.
    `ESC_ASSERT(a_bad_press_zero, o_result_valid && o_result.pressure_invalid |-> o_result.pressure == 32'd0, "pressure is not zero on a zero divisor")

    // Humidity never leaves the clamped range.
    `ESC_ASSERT(a_hum_limit, o_result_valid |-> o_result.humidity <= ESC_HUM_MAX, "humidity above full scale")

    // Reset drops every beat in flight.
    `ESC_ASSERT_NORST(a_quiet_after_reset, !i_rst_n |=> !o_result_valid, "result beat right after reset")

    // Reset empties the queue, so readings are taken at once.
    `ESC_ASSERT_NORST(a_ready_after_reset, !i_rst_n |=> !busy, "busy right after reset")

endmodule

bind env_sensor_compensation_unit esc_checker u_esc_checker (.*);

[bench/env_sensor_compensation_unit_test.sv]
// Self-checking testbench of the sensor compensation block: directed table plus random readings.
`timescale 1ns / 1ps

module env_sensor_compensation_unit_test import esc_pkg::*; ();

    localparam int LATENCY    = 76;
    localparam int STALL_MAX  = 4000;
    localparam int N_RANDOM   = 1650;
    localparam int N_DIRECTED = 12;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_esc_in           i_item;
    logic              o_result_valid;
    t_esc_out          o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ESC_AW-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    env_sensor_compensation_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_result_valid(o_result_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Calibration words as the bench believes them to be.
    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [39:0] cal_ha;
    logic [23:0] cal_hb;

    t_esc_out   compensated_q[$];
    int         mismatch_count;
    int         quiet_cycles;

    // Directed table: raw reading, optional typed-in result.
    typedef struct {
        t_esc_in  reading;
        bit       known;
        t_esc_out result;
    } t_row;
    t_row rows[N_DIRECTED];

    // Clock.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Arithmetic right shifts on plain vectors.
    function automatic logic [31:0] asr32(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    // Compensation of one raw reading with the current calibration words.
    function automatic t_esc_out compensate(t_esc_in rd);
        t_esc_out    res;
        logic [31:0] t1, t2, t3, a, v1, b, v2, fine, temp;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, lhs, q, r, s, rhs, hv, hs;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, e1, e2, press;
        logic [63:0] an, ad, quo;
        logic        bad;
        t1 = {16'b0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a = {15'b0, rd.adc_temperature[19:3]} - (t1 << 1);
        v1 = asr32(a * t2, 11);
        b = {16'b0, rd.adc_temperature[19:4]} - t1;
        v2 = asr32(asr32(b * b, 12) * t3, 14);
        fine = v1 + v2;
        temp = asr32(fine * 32'd5 + 32'd128, 8);

        // Humidity, 32-bit wrapping.
        h1 = {24'b0, cal_ha[7:0]};
        h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
        h3 = {24'b0, cal_ha[31:24]};
        h6 = {{24{cal_ha[39]}}, cal_ha[39:32]};
        h4 = {{20{cal_hb[11]}}, cal_hb[11:0]};
        h5 = {{20{cal_hb[23]}}, cal_hb[23:12]};
        x = fine - 32'd76800;
        lhs = asr32(({16'b0, rd.adc_humidity} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        q = asr32(x * h6, 10);
        r = asr32(x * h3, 11) + 32'd32768;
        s = asr32(q * r, 10) + 32'd2097152;
        rhs = asr32(s * h2 + 32'd8192, 14);
        hv = lhs * rhs;
        hs = asr32(hv, 15);
        hv = hv - asr32(asr32(hs * hs, 7) * h1, 4);
        if (hv[31]) begin
            hv = '0;
        end else if (hv > 32'd419430400) begin
            hv = 32'd419430400;
        end

        // Pressure, 64-bit wrapping.
        p1 = {48'b0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p5 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p6 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p7 = {{48{cal_pc[15]}}, cal_pc[15:0]};
        p8 = {{48{cal_pc[31]}}, cal_pc[31:16]};
        p9 = {{48{cal_pc[47]}}, cal_pc[47:32]};
        w1 = {{32{fine[31]}}, fine} - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
        press = '0;
        bad = (w1 == 0);
        if (!bad) begin
            p = 64'd1048576 - {44'b0, rd.adc_pressure};
            p = ((p << 31) - w2) * 64'd3125;
            an = p[63] ? -p : p;
            ad = w1[63] ? -w1 : w1;
            quo = an / ad;
            p = (p[63] != w1[63]) ? -quo : quo;
            e1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
            e2 = asr64(p8 * p, 19);
            press = asr64(p + e1 + e2, 8) + (p7 << 4);
        end

        res.temperature      = temp;
        res.humidity         = hv[28:12];
        res.pressure         = press[31:0];
        res.pressure_invalid = bad;
        return res;
    endfunction

    // One line per mismatch, and a count.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Result checker and watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_esc_out want;
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_result_valid) begin
                if (compensated_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_result), 64'd0);
                end else begin
                    want = compensated_q.pop_front();
                    if (o_result.temperature !== want.temperature)
                        report_mismatch("temperature", 64'(o_result.temperature),
                                        64'(want.temperature));
                    if (o_result.humidity !== want.humidity)
                        report_mismatch("humidity", 64'(o_result.humidity),
                                        64'(want.humidity));
                    if (o_result.pressure !== want.pressure)
                        report_mismatch("pressure", 64'(o_result.pressure),
                                        64'(want.pressure));
                    if (o_result.pressure_invalid !== want.pressure_invalid)
                        report_mismatch("pressure_invalid", 64'(o_result.pressure_invalid),
                                        64'(want.pressure_invalid));
                end
            end
            if (quiet_cycles > STALL_MAX) begin
                $display("env_sensor_compensation_unit regression: fail");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Register write through the APB-style port, setup phase then access phase.
    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ESC_AW'({index, 3'b000});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_TEMP_CAL: cal_temp = value[47:0];
            REG_PRESS_A:  cal_pa   = value[47:0];
            REG_PRESS_B:  cal_pb   = value[47:0];
            REG_PRESS_C:  cal_pc   = value[47:0];
            REG_HUM_A:    cal_ha   = value[39:0];
            REG_HUM_B:    cal_hb   = value[23:0];
            default: ;
        endcase
    endtask

    // Load a full calibration set.
    task automatic load_calibration(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
                                    logic [47:0] pc, logic [39:0] ha, logic [23:0] hb);
        write_reg(REG_TEMP_CAL, {16'b0, t});
        write_reg(REG_PRESS_A,  {16'b0, pa});
        write_reg(REG_PRESS_B,  {16'b0, pb});
        write_reg(REG_PRESS_C,  {16'b0, pc});
        write_reg(REG_HUM_A,    {24'b0, ha});
        write_reg(REG_HUM_B,    {40'b0, hb});
    endtask

    // Typical calibration with every coefficient drawn from a narrow random range.
    task automatic load_random_calibration();
        load_calibration({16'($urandom_range(0, 100) - 50), 16'($urandom_range(25000, 27500)),
                          16'($urandom_range(27000, 29000))},
                         {16'($urandom_range(2000, 4000)), 16'(-$urandom_range(10000, 11000)),
                          16'($urandom_range(34000, 38000))},
                         {16'(-$urandom_range(6000, 7500)), 16'($urandom_range(100, 300)),
                          16'($urandom_range(7000, 8000))},
                         {16'(-$urandom_range(9000, 11000)), 16'(-$urandom_range(10, 20)),
                          16'($urandom_range(0, 15))},
                         {8'($urandom_range(10, 40)), 8'($urandom_range(0, 10)),
                          16'($urandom_range(300, 400)), 8'($urandom_range(50, 100))},
                         {12'($urandom_range(0, 80)), 12'($urandom_range(250, 350))});
    endtask

    // Wait until every expected beat has come, then for the pipeline to drain.
    task automatic drain();
        int guard;
        guard = 0;
        while (compensated_q.size() != 0 && guard < 20 * STALL_MAX) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Present one reading and hold it until accepted.
    task automatic send_reading(t_esc_in rd, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= rd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        compensated_q.push_back(compensate(rd));
        @(negedge i_clk);
    endtask

    // A random reading, mostly in the working range, sometimes anywhere.
    function automatic t_esc_in random_reading();
        t_esc_in rd;
        if ($urandom_range(0, 3) == 0) begin
            rd = 56'({$urandom, $urandom});
        end else begin
            rd.adc_temperature = 20'($urandom_range(400000, 600000));
            rd.adc_pressure    = 20'($urandom_range(250000, 450000));
            rd.adc_humidity    = 16'($urandom_range(20000, 40000));
        end
        return rd;
    endfunction

    function automatic t_esc_out out_of(logic [31:0] t, logic [16:0] h, logic [31:0] p,
                                        logic bad);
        t_esc_out r;
        r.temperature = t;
        r.humidity = h;
        r.pressure = p;
        r.pressure_invalid = bad;
        return r;
    endfunction

    // Stimulus.
    initial begin
        int i, k, phase, idle_pct;
        t_esc_out want;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        cal_temp = '0;
        cal_pa = '0;
        cal_pb = '0;
        cal_pc = '0;
        cal_ha = '0;
        cal_hb = '0;

        // Table: after reset every word is zero, so temperature is zero and the
        // pressure divisor is zero; the rest are checked by prediction.
        rows[0] = '{'{20'h00000, 20'h00000, 16'h0000}, 1'b1,
                    out_of(32'd0, 17'd0, 32'd0, 1'b1)};
        rows[1] = '{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1,
                    out_of(32'd0, 17'd0, 32'd0, 1'b1)};
        rows[2] = '{'{20'h80000, 20'h12345, 16'h8000}, 1'b1,
                    out_of(32'd0, 17'd0, 32'd0, 1'b1)};
        rows[3] = '{'{20'h00000, 20'h00000, 16'h0000}, 1'b0, '0};
        rows[4] = '{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, '0};
        rows[5] = '{'{20'h7A120, 20'h5A3C0, 16'h6D60}, 1'b0, '0};
        rows[6] = '{'{20'h55555, 20'hAAAAA, 16'h5555}, 1'b0, '0};
        rows[7] = '{'{20'hAAAAA, 20'h55555, 16'hAAAA}, 1'b0, '0};
        rows[8] = '{'{20'h00000, 20'hFFFFF, 16'hFFFF}, 1'b0, '0};
        rows[9] = '{'{20'hFFFFF, 20'h00000, 16'h0000}, 1'b0, '0};
        rows[10] = '{'{20'h80000, 20'h80000, 16'hFFFF}, 1'b0, '0};
        rows[11] = '{'{20'h00001, 20'h00001, 16'h0001}, 1'b0, '0};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: reset values first, then typical, then extreme words.
        for (k = 0; k < 3; k++) begin
            if (k == 1) begin
                drain();
                load_calibration({16'd25000, 16'd26000, 16'd27504},
                                 {16'd36000, -16'sd10500, 16'd37000},
                                 {16'd7000, 16'd140, -16'sd7000},
                                 {-16'sd10000, -16'sd14, 16'd4000},
                                 {8'd30, 8'd0, 16'd360, 8'd75}, {12'd50, 12'd300});
            end else if (k == 2) begin
                drain();
                load_calibration('1, '1, '1, '1, '1, '1);
            end
            for (i = 0; i < N_DIRECTED; i++) begin
                if (k > 0 && i < 3) continue;
                send_reading(rows[i].reading, 0);
                if (rows[i].known) begin
                    want = compensated_q[$];
                    if (want !== rows[i].result)
                        report_mismatch("table row", 64'(want), 64'(rows[i].result));
                    compensated_q[$] = rows[i].result;
                end
            end
            start <= 1'b0;
        end

        // Extreme settings: large positive coefficients, and sign bits alone.
        drain();
        load_calibration(48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_7FFF,
                         48'h7FFF_7FFF_7FFF, 40'h7F_FF_7FFF_FF, 24'h7FF_7FF);
        for (i = 3; i < N_DIRECTED; i++) send_reading(rows[i].reading, 0);
        start <= 1'b0;
        drain();
        load_calibration(48'h8000_8000_0000, 48'h8000_8000_0001, 48'h8000_8000_8000,
                         48'h8000_8000_8000, 40'h80_00_8000_00, 24'h800_800);
        for (i = 3; i < N_DIRECTED; i++) send_reading(rows[i].reading, 0);
        start <= 1'b0;

        // Random part in three idling phases, recalibrating between bursts.
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 30 : (phase == 1) ? 55 : 0;
            for (i = 0; i < N_RANDOM / 3; i++) begin
                if (i % 110 == 0) begin
                    start <= 1'b0;
                    drain();
                    if ($urandom_range(0, 4) == 0) begin
                        load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                         48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                         40'({$urandom, $urandom}), 24'($urandom));
                    end else begin
                        load_random_calibration();
                    end
                end
                send_reading(random_reading(), (phase == 2 && (i / 40) % 2) ? 0 : idle_pct);
            end
            start <= 1'b0;
        end

        drain();
        if (mismatch_count == 0 && compensated_q.size() == 0) begin
            $display("env_sensor_compensation_unit regression: pass");
        end else begin
            $display("env_sensor_compensation_unit regression: fail");
        end
        $finish;
    end

endmodule
